FILE: rtl/rme_pkg.sv
package rme_pkg;

  // Number of CORDIC micro-rotations and fraction bits of the angle table.
  localparam int CORDIC_STAGES = 23;
  localparam int TABLE_FRAC    = 16;

  // Operand width at the atan2 input, CORDIC datapath width, angle
  // accumulator width and converted angle width.
  localparam int OPW = 32;
  localparam int CW  = 35;
  localparam int ZW  = 26;
  localparam int AW  = 32;

  // Operands that travel beside the square root pipeline.
  typedef struct packed {
    logic signed [15:0]    s;
    logic signed [OPW-1:0] roll_y;
    logic signed [OPW-1:0] roll_x;
    logic signed [OPW-1:0] yaw_y;
    logic signed [OPW-1:0] yaw_x;
    logic                  lock_pos;
    logic                  lock_neg;
  } side_t;

  // atan(2^-i) in degrees with TABLE_FRAC fraction bits.
  function automatic logic signed [ZW-1:0] atan_deg(input int idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/rme_intf.sv
interface rme_mat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] col0_row0;
  logic signed [15:0] col0_row1;
  logic signed [15:0] col0_row2;
  logic signed [15:0] col1_row0;
  logic signed [15:0] col2_row0;
  logic signed [15:0] col2_row1;
  logic signed [15:0] col2_row2;

  modport source (output valid, output col0_row0, output col0_row1, output col0_row2,
                  output col1_row0, output col2_row0, output col2_row1,
                  output col2_row2, input ready);
  modport sink   (input valid, input col0_row0, input col0_row1, input col0_row2,
                  input col1_row0, input col2_row0, input col2_row1,
                  input col2_row2, output ready);
endinterface

interface rme_ang_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_deg;
  logic signed [14:0] pitch_deg;
  logic signed [15:0] roll_deg;

  modport source (output valid, output yaw_deg, output pitch_deg, output roll_deg,
                  input ready);
  modport sink   (input valid, input yaw_deg, input pitch_deg, input roll_deg,
                  output ready);
endinterface

FILE: rtl/rme_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module rme_isqrt #(
  parameter int NB = 15,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*NB-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic [NB-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  localparam int RW = 2 * NB;

  logic [RW-1:0] r_q  [NB];
  logic [NB-1:0] q_q  [NB];
  logic [SW-1:0] sb_q [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    localparam int B = NB - 1 - k;
    logic [RW-1:0] r_in;
    logic [NB-1:0] q_in;
    logic [SW-1:0] sb_in;
    logic [RW:0]   trial;
    logic [RW-1:0] r_d;
    logic [NB-1:0] q_d;

    if (k == 0) begin : g_first
      assign r_in  = rad_i;
      assign q_in  = '0;
      assign sb_in = side_i;
    end else begin : g_next
      assign r_in  = r_q[k-1];
      assign q_in  = q_q[k-1];
      assign sb_in = sb_q[k-1];
    end

    always_comb begin
      trial = ((RW+1)'(q_in) << (B + 1)) + ((RW+1)'(1) << (2 * B));
      r_d   = r_in;
      q_d   = q_in;
      if ({1'b0, r_in} >= trial) begin
        r_d = r_in - trial[RW-1:0];
        q_d = q_in | (NB'(1) << B);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= r_d;
        q_q[k]  <= q_d;
        sb_q[k] <= sb_in;
      end
    end
  end

  assign root_o = q_q[NB-1];
  assign side_o = sb_q[NB-1];

endmodule

FILE: rtl/rme_atan2.sv
// Pipelined vectoring CORDIC atan2 in degrees: normalize, quarter turn,
// the micro-rotations, then rounding or widening to the output format and clamping.
module rme_atan2 #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [rme_pkg::OPW-1:0] y_i,
  input  logic signed [rme_pkg::OPW-1:0] x_i,
  output logic signed [rme_pkg::AW-1:0]  angle_o
);

  localparam int CW  = rme_pkg::CW;
  localparam int ZW  = rme_pkg::ZW;
  localparam int AW  = rme_pkg::AW;
  localparam int STG = rme_pkg::CORDIC_STAGES;
  localparam logic signed [AW-1:0] LIM = AW'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] QTR = ZW'(90) <<< rme_pkg::TABLE_FRAC;

  // Normalization stage.
  logic [31:0] ax, ay, m, mm;
  logic [4:0]  sh;
  logic signed [CW-1:0] xn_q, yn_q;
  logic                 zn_q;

  always_comb begin
    ax = x_i[rme_pkg::OPW-1] ? 32'(-x_i) : 32'(x_i);
    ay = y_i[rme_pkg::OPW-1] ? 32'(-y_i) : 32'(y_i);
    m  = (ax > ay) ? ax : ay;
    mm = m;
    sh = '0;
    if (mm < 32'h0000_8000) begin mm = mm << 16; sh = sh + 5'd16; end
    if (mm < 32'h0080_0000) begin mm = mm << 8;  sh = sh + 5'd8;  end
    if (mm < 32'h0800_0000) begin mm = mm << 4;  sh = sh + 5'd4;  end
    if (mm < 32'h2000_0000) begin mm = mm << 2;  sh = sh + 5'd2;  end
    if (mm < 32'h4000_0000) begin mm = mm << 1;  sh = sh + 5'd1;  end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xn_q <= CW'(x_i) <<< sh;
      yn_q <= CW'(y_i) <<< sh;
      zn_q <= (m == 32'd0);
    end
  end

  // Quarter turn into the right half plane.
  logic signed [CW-1:0] xq_q, yq_q;
  logic signed [ZW-1:0] zq_q;
  logic                 zeq_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zeq_q <= zn_q;
      if (!xn_q[CW-1]) begin
        xq_q <= xn_q;
        yq_q <= yn_q;
        zq_q <= '0;
      end else if (!yn_q[CW-1]) begin
        xq_q <= yn_q;
        yq_q <= -xn_q;
        zq_q <= QTR;
      end else begin
        xq_q <= -yn_q;
        yq_q <= xn_q;
        zq_q <= -QTR;
      end
    end
  end

  // Micro-rotations.
  logic signed [CW-1:0] xs_q [STG];
  logic signed [CW-1:0] ys_q [STG];
  logic signed [ZW-1:0] zs_q [STG];
  logic                 zz_q [STG];

  for (genvar i = 0; i < STG; i++) begin : g_rot
    logic signed [CW-1:0] x_in, y_in;
    logic signed [ZW-1:0] z_in;
    logic                 zz_in;

    if (i == 0) begin : g_first
      assign x_in  = xq_q;
      assign y_in  = yq_q;
      assign z_in  = zq_q;
      assign zz_in = zeq_q;
    end else begin : g_next
      assign x_in  = xs_q[i-1];
      assign y_in  = ys_q[i-1];
      assign z_in  = zs_q[i-1];
      assign zz_in = zz_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zz_q[i] <= zz_in;
        if (!y_in[CW-1]) begin
          xs_q[i] <= x_in + (y_in >>> i);
          ys_q[i] <= y_in - (x_in >>> i);
          zs_q[i] <= z_in + rme_pkg::atan_deg(i);
        end else begin
          xs_q[i] <= x_in - (y_in >>> i);
          ys_q[i] <= y_in + (x_in >>> i);
          zs_q[i] <= z_in - rme_pkg::atan_deg(i);
        end
      end
    end
  end

  // Conversion to the output format, then clamping.
  logic signed [AW-1:0] za, conv, clamped;
  assign za = AW'(zs_q[STG-1]);

  if (ANGLE_FRAC_BITS < rme_pkg::TABLE_FRAC) begin : g_round
    localparam int SH = rme_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;
    assign conv = (za + (AW'(32'sd1) <<< (SH - 1))) >>> SH;
  end else begin : g_widen
    assign conv = za <<< (ANGLE_FRAC_BITS - rme_pkg::TABLE_FRAC);
  end

  always_comb begin
    if (conv > LIM) begin
      clamped = LIM;
    end else if (conv < -LIM) begin
      clamped = -LIM;
    end else begin
      clamped = conv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_o <= zz_q[STG-1] ? '0 : clamped;
    end
  end

endmodule

FILE: rtl/rotation_matrix_to_euler.sv
// Rotation matrix to Z-Y-X Euler angles (yaw, pitch, roll) in degrees.
// The input channel mat_i carries seven entries of a 3x3 rotation matrix,
// signed with MATRIX_FRAC_BITS fraction bits; one transfer is one matrix.
// The output channel ang_o returns yaw, pitch and roll, signed degrees with
// ANGLE_FRAC_BITS fraction bits; each matrix gives exactly one transfer.
// From input transfer to output valid a matrix passes the input capture
// and squaring registers, the square root pipeline, the CORDIC atan2
// pipeline and one output register. Throughput is one matrix per cycle
// when the receiver does not stall; the three atan2 units run side by side.
// When the receiver holds ready low while a result is valid, the whole
// pipeline freezes in place and mat_i.ready drops; nothing is lost or
// repeated, and it resumes in the same cycle that ready returns.
// Reset clears all valid bits so no output transfer appears until a new
// matrix has passed through; data registers are not reset.
module rotation_matrix_to_euler #(
  parameter int MATRIX_FRAC_BITS = 14,
  parameter int ANGLE_FRAC_BITS  = 7
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rme_mat_if.sink   mat_i,
  rme_ang_if.source ang_o
);

  localparam int NB  = MATRIX_FRAC_BITS + 1;
  localparam int RW  = 2 * NB;
  localparam int OPW = rme_pkg::OPW;
  localparam int AW  = rme_pkg::AW;
  localparam int CL  = rme_pkg::CORDIC_STAGES + 3;
  localparam int L   = NB + CL + 3;
  localparam int SW  = $bits(rme_pkg::side_t);

  localparam logic signed [31:0] ONE     = 32'sd1 <<< MATRIX_FRAC_BITS;
  localparam logic [RW-1:0]      ONE_SQ  = RW'(1) << (2 * MATRIX_FRAC_BITS);
  localparam logic signed [AW-1:0] QUARTER = AW'(90) <<< ANGLE_FRAC_BITS;

  // One valid bit per pipeline stage; every stage moves together.
  logic [L-1:0] v_q;
  logic         en;

  assign en          = !v_q[L-1] || ang_o.ready;
  assign mat_i.ready = en;
  assign ang_o.valid = v_q[L-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[L-2:0], mat_i.valid};
    end
  end

  // Stage 0: saturate the pitch sine, detect gimbal lock and pick the roll
  // operands for either branch.
  logic signed [31:0]   s_wide, s_sat;
  rme_pkg::side_t       side_d, side0_q, side1_q, side2;
  logic [RW-1:0]        rem1_q;
  logic signed [31:0]   sq;

  always_comb begin
    s_wide = 32'(mat_i.col2_row0);
    if (s_wide > ONE) begin
      s_sat = ONE;
    end else if (s_wide < -ONE) begin
      s_sat = -ONE;
    end else begin
      s_sat = s_wide;
    end
    side_d.s        = s_sat[15:0];
    side_d.lock_pos = (s_sat == ONE);
    side_d.lock_neg = (s_sat == -ONE);
    side_d.yaw_y    = OPW'(mat_i.col1_row0);
    side_d.yaw_x    = OPW'(mat_i.col0_row0);
    if (side_d.lock_pos) begin
      side_d.roll_y = -OPW'(mat_i.col0_row1);
      side_d.roll_x = -OPW'(mat_i.col0_row2);
    end else if (side_d.lock_neg) begin
      side_d.roll_y = OPW'(mat_i.col0_row1);
      side_d.roll_x = OPW'(mat_i.col0_row2);
    end else begin
      side_d.roll_y = OPW'(mat_i.col2_row1);
      side_d.roll_x = OPW'(mat_i.col2_row2);
    end
  end

  // Stage 1: one minus the squared sine, the radicand of the cosine.
  assign sq = side0_q.s * side0_q.s;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side0_q <= side_d;
      side1_q <= side0_q;
      rem1_q  <= ONE_SQ - RW'(unsigned'(sq));
    end
  end

  // Cosine of pitch; the other operands ride alongside.
  logic [NB-1:0] cos_root;
  logic [SW-1:0] side2_bits;

  rme_isqrt #(
    .NB (NB),
    .SW (SW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rem1_q),
    .side_i (side1_q),
    .root_o (cos_root),
    .side_o (side2_bits)
  );

  assign side2 = rme_pkg::side_t'(side2_bits);

  // Three atan2 units in parallel: asin through atan2(s, c), roll and yaw.
  logic signed [AW-1:0] pitch_a, roll_a, yaw_a;

  rme_atan2 #(.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)) u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (OPW'(side2.s)),
    .x_i     (signed'(OPW'(cos_root))),
    .angle_o (pitch_a)
  );

  rme_atan2 #(.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)) u_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (side2.roll_y),
    .x_i     (side2.roll_x),
    .angle_o (roll_a)
  );

  rme_atan2 #(.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)) u_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (side2.yaw_y),
    .x_i     (side2.yaw_x),
    .angle_o (yaw_a)
  );

  // Gimbal lock flags follow the CORDIC latency.
  logic [1:0] lock_q [CL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      lock_q[0] <= {side2.lock_pos, side2.lock_neg};
      for (int i = 1; i < CL; i++) begin
        lock_q[i] <= lock_q[i-1];
      end
    end
  end

  // Output stage: pitch is limited to a quarter turn and negated; at gimbal
  // lock yaw is zero and pitch is a fixed quarter turn.
  logic signed [AW-1:0] pitch_c, pitch_d, yaw_d;
  logic signed [15:0]   yaw_q, roll_q;
  logic signed [14:0]   pitch_q;

  always_comb begin
    if (pitch_a > QUARTER) begin
      pitch_c = QUARTER;
    end else if (pitch_a < -QUARTER) begin
      pitch_c = -QUARTER;
    end else begin
      pitch_c = pitch_a;
    end
    if (lock_q[CL-1][1]) begin
      pitch_d = -QUARTER;
      yaw_d   = '0;
    end else if (lock_q[CL-1][0]) begin
      pitch_d = QUARTER;
      yaw_d   = '0;
    end else begin
      pitch_d = -pitch_c;
      yaw_d   = -yaw_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_q   <= yaw_d[15:0];
      pitch_q <= pitch_d[14:0];
      roll_q  <= roll_a[15:0];
    end
  end

  assign ang_o.yaw_deg   = yaw_q;
  assign ang_o.pitch_deg = pitch_q;
  assign ang_o.roll_deg  = roll_q;

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for rotation_matrix_to_euler.
// Matrices are driven on the mat_i channel and every angle transfer on ang_o
// is compared against an in-bench fixed-point model of the Euler extraction:
// a 23-stage vectoring CORDIC atan2, with asin built from atan2 and an
// integer square root. Both channels idle at random, and one phase stalls
// the receiver long enough to back the pipeline up into the input.
module tb_top;

  localparam int MFB     = 14;
  localparam int AFB     = 7;
  localparam int LATENCY = MFB + 30;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rme_mat_if mat_if ();
  rme_ang_if ang_if ();

  rotation_matrix_to_euler #(
    .MATRIX_FRAC_BITS(MFB),
    .ANGLE_FRAC_BITS (AFB)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .mat_i (mat_if.sink),
    .ang_o (ang_if.source)
  );

  always #6 clk_i = ~clk_i;

  // Expected angle triples, oldest first.
  angles_t expected_angles[$];
  int      mismatches = 0;
  longint  cycles = 0;
  bit      in_idle_on = 1'b1;
  bit      out_idle_on = 1'b1;
  int      out_hold = 0;
  // A test asks for a hold-off by bumping hold_requests; the receiver
  // process notices the change and does the counting itself.
  int      hold_requests = 0;
  int      holds_served = 0;

  // atan(2^-i) in degrees with 16 fraction bits.
  longint atan_steps[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                             58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
                             115, 57, 29, 14, 7, 4, 2, 1};

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan2(y, x) in degrees with AFB fraction bits, clamped to +-180.
  function automatic longint atan2_degrees(longint y, longint x);
    longint ax, ay, m, z, t, dx, dy;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    m = ax > ay ? ax : ay;
    z = 0;
    if (m == 0) return 0;
    while (m < (longint'(1) << 30)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    // Fold the left half plane onto the right one with a quarter turn.
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t;
        z = longint'(90) << 16;
      end else begin
        t = x; x = -y; y = t;
        z = -(longint'(90) << 16);
      end
    end
    for (int i = 0; i < 23; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_steps[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_steps[i];
      end
    end
    z = shr_floor(z + (longint'(1) << (16 - AFB - 1)), 16 - AFB);
    return clamp_to(z, longint'(180) << AFB);
  endfunction

  function automatic angles_t euler_angles(logic signed [15:0] m[7]);
    longint one, s, quarter, yaw, pitch, roll, c;
    angles_t a;
    one = longint'(1) << MFB;
    quarter = longint'(90) << AFB;
    s = clamp_to(longint'(m[4]), one);
    if (s == one) begin
      // Gimbal lock with the sine at plus one.
      yaw = 0;
      pitch = -quarter;
      roll = atan2_degrees(-longint'(m[1]), -longint'(m[2]));
    end else if (s == -one) begin
      yaw = 0;
      pitch = quarter;
      roll = atan2_degrees(longint'(m[1]), longint'(m[2]));
    end else begin
      c = int_sqrt(one * one - s * s);
      pitch = -clamp_to(atan2_degrees(s, c), quarter);
      roll = atan2_degrees(longint'(m[5]), longint'(m[6]));
      yaw = -atan2_degrees(longint'(m[3]), longint'(m[0]));
    end
    a.yaw = yaw[15:0];
    a.pitch = pitch[14:0];
    a.roll = roll[15:0];
    return a;
  endfunction

  // Runaway guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random idling, plus a counted hold-off when requested.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_if.ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      out_hold <= HOLD_CYCLES - 1;
      ang_if.ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      ang_if.ready <= 1'b0;
    end else begin
      ang_if.ready <= !(out_idle_on && ($urandom_range(99) < 31));
    end
  end

  // Result checker: every output transfer is matched with the oldest expectation.
  always @(posedge clk_i) begin
    angles_t want;
    if (rst_ni && ang_if.valid && ang_if.ready) begin
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transfer yaw=%0d pitch=%0d roll=%0d",
                   ang_if.yaw_deg, ang_if.pitch_deg, ang_if.roll_deg);
      end else begin
        want = expected_angles.pop_front();
        if (ang_if.yaw_deg !== want.yaw || ang_if.pitch_deg !== want.pitch ||
            ang_if.roll_deg !== want.roll) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected yaw=%0d pitch=%0d roll=%0d, got %0d %0d %0d",
                     want.yaw, want.pitch, want.roll,
                     ang_if.yaw_deg, ang_if.pitch_deg, ang_if.roll_deg);
        end
      end
    end
  end

  // Offers one matrix and waits for its transfer. The expectation is queued
  // at the accepting edge, ahead of any result sampled later.
  task automatic send_matrix(logic signed [15:0] m[7]);
    while (in_idle_on && ($urandom_range(99) < 31)) begin
      mat_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    mat_if.valid <= 1'b1;
    mat_if.col0_row0 <= m[0];
    mat_if.col0_row1 <= m[1];
    mat_if.col0_row2 <= m[2];
    mat_if.col1_row0 <= m[3];
    mat_if.col2_row0 <= m[4];
    mat_if.col2_row1 <= m[5];
    mat_if.col2_row2 <= m[6];
    do @(posedge clk_i); while (!mat_if.ready);
    expected_angles.push_back(euler_angles(m));
    @(negedge clk_i);
  endtask

  task automatic release_input();
    mat_if.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_entry();
    case ($urandom_range(9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return $urandom_range(3) == 0 ? 16'sh7FFF : 16'sh8000;
      3: return 16'(int'($urandom_range(32)) - 16);
      default: return 16'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // Random matrix: mostly in-range entries, a few outside, some at gimbal lock.
  task automatic random_matrix(output logic signed [15:0] m[7]);
    for (int k = 0; k < 7; k++) m[k] = rand_entry();
    if ($urandom_range(9) == 0) m[4] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
    else if ($urandom_range(19) == 0) m[4] = 16'($urandom);
  endtask

  task automatic wait_drained();
    release_input();
    while (expected_angles.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    logic signed [15:0] m[7];
    logic signed [15:0] vals[6] = '{16'sd16384, -16'sd16384, 16'sd0,
                                   16'sh7FFF, 16'sh8000, 16'sd11585};
    // Identity, then zero vectors and both gimbal locks.
    m = '{16'sd16384, 0, 0, 0, 0, 0, 16'sd16384};
    send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0};
    send_matrix(m);
    m = '{0, 16'sd5000, -16'sd9000, 0, 16'sd16384, 0, 0};
    send_matrix(m);
    m = '{0, 16'sd5000, -16'sd9000, 0, -16'sd16384, 0, 0};
    send_matrix(m);
    m = '{0, 0, 0, 0, 16'sd16384, 0, 0};
    send_matrix(m);
    // Sine beyond one in both directions saturates into the lock branch.
    m = '{1, 2, 3, 4, 16'sh7FFF, 5, 6};
    send_matrix(m);
    m = '{1, 2, 3, 4, 16'sh8000, 5, 6};
    send_matrix(m);
    m = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd16383, 16'sh8000, 16'sh8000};
    send_matrix(m);
    m = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, -16'sd16383, 16'sh7FFF, 16'sh7FFF};
    send_matrix(m);
    for (int k = 0; k < 14; k++) begin
      for (int j = 0; j < 7; j++) m[j] = vals[(k + j * 5) % 6];
      send_matrix(m);
    end
  endtask

  task automatic test_random(int count);
    logic signed [15:0] m[7];
    for (int n = 0; n < count; n++) begin
      random_matrix(m);
      send_matrix(m);
    end
  endtask

  // Receiver stalls for a long stretch while matrices keep coming.
  task automatic test_backpressure();
    logic signed [15:0] m[7];
    hold_requests++;
    in_idle_on = 1'b0;
    for (int n = 0; n < 120; n++) begin
      random_matrix(m);
      send_matrix(m);
    end
    in_idle_on = 1'b1;
  endtask

  // No idling on either side: back-to-back transfers.
  task automatic test_streaming();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    test_random(250);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    mat_if.valid = 1'b0;
    mat_if.col0_row0 = '0;
    mat_if.col0_row1 = '0;
    mat_if.col0_row2 = '0;
    mat_if.col1_row0 = '0;
    mat_if.col2_row0 = '0;
    mat_if.col2_row1 = '0;
    mat_if.col2_row2 = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(350);
    // The sender pauses here until every result is back.
    wait_drained();
    test_backpressure();
    test_streaming();
    test_random(380);

    wait_drained();
    repeat (LATENCY + 10) @(negedge clk_i);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
